FILE: design/pca_pkg.sv
// pca_pkg: shared types, mode codes, register indexes and helpers for the
// pixel colour adjust block
// no dependencies
`default_nettype none

package pca_pkg;

    localparam int CH_W   = 8;
    localparam int AMT_W  = 10;
    localparam int MODE_W = 3;

    // mode register codes
    localparam logic [MODE_W-1:0] MODE_BRIGHT   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CONTRAST = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SAT      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_HUE      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_GRAY     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_NEG      = 3'd5;
    localparam logic [MODE_W-1:0] MODE_OPACITY  = 3'd6;

    // configuration register indexes
    localparam logic REG_MODE   = 1'b0;
    localparam logic REG_AMOUNT = 1'b1;

    // divider geometry: numerator, divisor and quotient widths, lanes
    localparam int DIV_NW = 25;
    localparam int DIV_DW = 17;
    localparam int DIV_QW = 9;
    localparam int DIV_LN = 2;

    typedef struct packed {
        logic [CH_W-1:0] red_in;
        logic [CH_W-1:0] green_in;
        logic [CH_W-1:0] blue_in;
        logic [CH_W-1:0] alpha_in;
    } pix_in_t;

    typedef struct packed {
        logic [CH_W-1:0] red_out;
        logic [CH_W-1:0] green_out;
        logic [CH_W-1:0] blue_out;
        logic [CH_W-1:0] alpha_out;
    } pix_out_t;

    // data riding alongside the divider: non-hsv result, value, grey flag
    typedef struct packed {
        pix_out_t        res;
        logic [CH_W-1:0] val;
        logic            achrom;
    } hsv_side_t;

    function automatic logic [CH_W-1:0] clamp_u8(input logic signed [13:0] x);
        logic [CH_W-1:0] r;
        if (x < 14'sd0)
            r = '0;
        else if (x > 14'sd255)
            r = 8'd255;
        else
            r = x[CH_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: design/pixel_color_adjust.sv
// pixel_color_adjust: top level, configuration registers, front stages
// and pipeline glue; depends on pca_pkg, pca_div and pca_hsv_back
//
// One RGBA pixel per clock in and out: a pixel beat is taken every cycle
// the result side is not blocked, and results leave in order after passing
// through two front stages, nine divider stages that produce one hue and
// one saturation quotient bit each, five hsv-to-rgb stages and the output
// register. A stall on the result side holds the whole pipeline;
// nothing is dropped. Write mode and amount only while no pixel is in flight.
`default_nettype none

module pixel_color_adjust (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              pix_valid,
    output logic                                   pix_ready,
    input  wire pca_pkg::pix_in_t                  pix,
    output logic                                   res_valid,
    input  wire logic                              res_ready,
    output pca_pkg::pix_out_t                      res,
    input  wire logic                              cfg_we,
    input  wire logic                              cfg_index,
    input  wire logic [pca_pkg::AMT_W-1:0]         cfg_data
);

    logic                               adv;
    logic [pca_pkg::MODE_W-1:0]         mode_reg;
    logic signed [pca_pkg::AMT_W-1:0]   amount_reg;

    // stage a
    logic                               a_vld_reg;
    pca_pkg::pix_in_t                   a_pix_reg;
    logic [7:0]                         a_mx_reg, a_delta_reg;
    logic                               a_rmax_reg, a_gmax_reg;
    logic signed [2:0][19:0]            a_cp_reg;
    logic [2:0][23:0]                   a_gy_reg;

    // stage b
    logic                               b_vld_reg;
    pca_pkg::hsv_side_t                 b_side_reg;
    logic [pca_pkg::DIV_LN-1:0][pca_pkg::DIV_NW-1:0] b_num_reg;
    logic [pca_pkg::DIV_LN-1:0][pca_pkg::DIV_DW-1:0] b_den_reg;

    logic [7:0]                         mx, mn;
    logic [2:0][7:0]                    ch;
    logic signed [8:0]                  cdiff;
    logic signed [10:0]                 cfac;
    logic signed [2:0][19:0]            cp_next;
    logic [2:0][23:0]                   gy_next;

    logic [2:0][7:0]                    b_ch;
    logic signed [19:0]                 cq;
    logic [2:0][7:0]                    con;
    logic [2:0][7:0]                    bri;
    logic [23:0]                        gsum;
    logic signed [25:0]                 dl, dgb, dbr, drg, nr, ng, nb, nsel, nn;
    pca_pkg::pix_out_t                  simple;
    pca_pkg::hsv_side_t                 b_side_next;
    logic [pca_pkg::DIV_LN-1:0][pca_pkg::DIV_NW-1:0] b_num_next;
    logic [pca_pkg::DIV_LN-1:0][pca_pkg::DIV_DW-1:0] b_den_next;

    logic                               dv_vld;
    logic [pca_pkg::DIV_LN-1:0][pca_pkg::DIV_QW-1:0] dv_quo;
    pca_pkg::hsv_side_t                 dv_side;

    assign adv       = !res_valid || res_ready;
    assign pix_ready = adv;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= pca_pkg::MODE_BRIGHT;
            amount_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pca_pkg::REG_MODE:   mode_reg   <= cfg_data[pca_pkg::MODE_W-1:0];
                pca_pkg::REG_AMOUNT: amount_reg <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    // stage a: max/min, contrast and luma products
    always_comb
    begin
        ch[0] = pix.red_in;
        ch[1] = pix.green_in;
        ch[2] = pix.blue_in;
        mx = (ch[0] >= ch[1]) ? ((ch[0] >= ch[2]) ? ch[0] : ch[2])
                              : ((ch[1] >= ch[2]) ? ch[1] : ch[2]);
        mn = (ch[0] <= ch[1]) ? ((ch[0] <= ch[2]) ? ch[0] : ch[2])
                              : ((ch[1] <= ch[2]) ? ch[1] : ch[2]);
        cfac = 11'(amount_reg) + 11'sd128;
        cdiff = '0;
        for (int i = 0; i < 3; i++)
        begin
            cdiff      = $signed({1'b0, ch[i]}) - 9'sd127;
            cp_next[i] = 20'(cdiff) * 20'(cfac);
        end
        gy_next[0] = 24'(ch[0]) * 24'd13933;
        gy_next[1] = 24'(ch[1]) * 24'd46871;
        gy_next[2] = 24'(ch[2]) * 24'd4732;
    end

    // stage b: simple results and divider operands
    always_comb
    begin
        b_ch[0] = a_pix_reg.red_in;
        b_ch[1] = a_pix_reg.green_in;
        b_ch[2] = a_pix_reg.blue_in;
        cq = '0;
        for (int i = 0; i < 3; i++)
        begin
            // truncating division by 128
            cq     = a_cp_reg[i][19] ? (($signed(a_cp_reg[i]) + 20'sd127) >>> 7)
                                     : ($signed(a_cp_reg[i]) >>> 7);
            con[i] = pca_pkg::clamp_u8(14'(cq) + 14'sd127);
            bri[i] = pca_pkg::clamp_u8($signed({6'b0, b_ch[i]}) + 14'(amount_reg));
        end
        gsum = a_gy_reg[0] + a_gy_reg[1] + a_gy_reg[2] + 24'd32768;

        simple.red_out   = b_ch[0];
        simple.green_out = b_ch[1];
        simple.blue_out  = b_ch[2];
        simple.alpha_out = a_pix_reg.alpha_in;
        case (mode_reg)
            pca_pkg::MODE_BRIGHT:
            begin
                simple.red_out = bri[0]; simple.green_out = bri[1];
                simple.blue_out = bri[2];
            end
            pca_pkg::MODE_CONTRAST:
            begin
                simple.red_out = con[0]; simple.green_out = con[1];
                simple.blue_out = con[2];
            end
            pca_pkg::MODE_GRAY:
            begin
                simple.red_out = gsum[23:16]; simple.green_out = gsum[23:16];
                simple.blue_out = gsum[23:16];
            end
            pca_pkg::MODE_NEG:
            begin
                simple.red_out = ~b_ch[0]; simple.green_out = ~b_ch[1];
                simple.blue_out = ~b_ch[2];
            end
            pca_pkg::MODE_OPACITY:
                simple.alpha_out = pca_pkg::clamp_u8($signed({6'b0, a_pix_reg.alpha_in})
                                                     + 14'(amount_reg));
            default: ;
        endcase

        // hue numerator in centidegrees, doubled for rounding
        dl  = $signed({18'b0, a_delta_reg});
        dgb = 26'($signed({1'b0, b_ch[1]}) - $signed({1'b0, b_ch[2]}));
        dbr = 26'($signed({1'b0, b_ch[2]}) - $signed({1'b0, b_ch[0]}));
        drg = 26'($signed({1'b0, b_ch[0]}) - $signed({1'b0, b_ch[1]}));
        nr  = dgb * 26'sd6000;
        if (nr < 26'sd0)
            nr = nr + dl * 26'sd36000;
        ng  = dl * 26'sd12000 + dbr * 26'sd6000;
        nb  = dl * 26'sd24000 + drg * 26'sd6000;
        nsel = a_rmax_reg ? nr : (a_gmax_reg ? ng : nb);
        nn   = (nsel <<< 1) + dl;

        // lane 0 hue, lane 1 saturation; both fold the final truncation in
        b_num_next[0] = nn[pca_pkg::DIV_NW-1:0];
        b_den_next[0] = pca_pkg::DIV_DW'(a_delta_reg) * pca_pkg::DIV_DW'(200);
        b_num_next[1] = pca_pkg::DIV_NW'(a_delta_reg) * pca_pkg::DIV_NW'(131070)
                        + pca_pkg::DIV_NW'(a_mx_reg);
        b_den_next[1] = {a_mx_reg, 9'b0};

        b_side_next.res    = simple;
        b_side_next.val    = a_mx_reg;
        b_side_next.achrom = (a_delta_reg == 8'd0);
    end

    // front stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg <= pix_valid;
            b_vld_reg <= a_vld_reg;
        end
    end

    // front stage data
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_pix_reg   <= pix;
            a_mx_reg    <= mx;
            a_delta_reg <= mx - mn;
            a_rmax_reg  <= (pix.red_in == mx);
            a_gmax_reg  <= (pix.green_in == mx);
            a_cp_reg    <= cp_next;
            a_gy_reg    <= gy_next;
            b_side_reg  <= b_side_next;
            b_num_reg   <= b_num_next;
            b_den_reg   <= b_den_next;
        end
    end

    pca_div #(
        .NW (pca_pkg::DIV_NW),
        .DW (pca_pkg::DIV_DW),
        .QW (pca_pkg::DIV_QW),
        .LN (pca_pkg::DIV_LN),
        .SW ($bits(pca_pkg::hsv_side_t))
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (b_vld_reg),
        .num      (b_num_reg),
        .den      (b_den_reg),
        .side     (b_side_reg),
        .out_vld  (dv_vld),
        .quo      (dv_quo),
        .side_out (dv_side)
    );

    pca_hsv_back #(
        .QW (pca_pkg::DIV_QW)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_vld  (dv_vld),
        .hq      (dv_quo[0]),
        .sq      (dv_quo[1]),
        .side    (dv_side),
        .mode    (mode_reg),
        .amount  (amount_reg),
        .out_vld (res_valid),
        .out_pix (res)
    );

`ifndef SYNTHESIS
    // the pipeline only stalls when a result is waiting
    assert property (@(posedge clk) disable iff (!rst_n) !pix_ready |-> res_valid)
        else $error("input stalled with no result pending");

    // grayscale results carry equal colour channels
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && mode_reg == pca_pkg::MODE_GRAY)
        |-> (res.red_out == res.green_out && res.green_out == res.blue_out))
        else $error("grayscale channels differ");

    // a stalled front stage keeps its beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (b_vld_reg && !adv) |=> b_vld_reg)
        else $error("front stage beat lost during stall");
`endif

endmodule

`default_nettype wire

FILE: design/pca_div.sv
// pca_div: pipelined restoring divider, one quotient bit per stage,
// several lanes in lock step with a side payload; uses no package
`default_nettype none

module pca_div #(
    parameter int NW = 25,
    parameter int DW = 17,
    parameter int QW = 9,
    parameter int LN = 2,
    parameter int SW = 1
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       en,
    input  wire logic                       in_vld,
    input  wire logic [LN-1:0][NW-1:0]      num,
    input  wire logic [LN-1:0][DW-1:0]      den,
    input  wire logic [SW-1:0]              side,
    output logic                            out_vld,
    output logic [LN-1:0][QW-1:0]           quo,
    output logic [SW-1:0]                   side_out
);

    localparam int CW = NW + QW;

    logic [QW-1:0]                  vld_reg;
    logic [QW-1:0][LN-1:0][NW-1:0]  rem_reg;
    logic [QW-1:0][LN-1:0][DW-1:0]  den_reg;
    logic [QW-1:0][LN-1:0][QW-1:0]  quo_reg;
    logic [QW-1:0][SW-1:0]          side_reg;

    for (genvar st = 0; st < QW; st++) begin : g_st
        logic                    vld_i;
        logic [LN-1:0][NW-1:0]   rem_i;
        logic [LN-1:0][DW-1:0]   den_i;
        logic [LN-1:0][QW-1:0]   quo_i;
        logic [SW-1:0]           side_i;
        logic [LN-1:0][CW-1:0]   dsh;
        logic [LN-1:0][NW-1:0]   rem_next;
        logic [LN-1:0][QW-1:0]   quo_next;

        if (st == 0) begin : g_first
            assign vld_i  = in_vld;
            assign rem_i  = num;
            assign den_i  = den;
            assign quo_i  = '0;
            assign side_i = side;
        end else begin : g_rest
            assign vld_i  = vld_reg[st-1];
            assign rem_i  = rem_reg[st-1];
            assign den_i  = den_reg[st-1];
            assign quo_i  = quo_reg[st-1];
            assign side_i = side_reg[st-1];
        end

        // trial subtract of the divisor shifted to this quotient bit
        always_comb
        begin
            for (int ln = 0; ln < LN; ln++)
            begin
                dsh[ln] = CW'(den_i[ln]) << (QW - 1 - st);
                if (CW'(rem_i[ln]) >= dsh[ln])
                begin
                    rem_next[ln] = rem_i[ln] - dsh[ln][NW-1:0];
                    quo_next[ln] = quo_i[ln] | (QW'(1) << (QW - 1 - st));
                end
                else
                begin
                    rem_next[ln] = rem_i[ln];
                    quo_next[ln] = quo_i[ln];
                end
            end
        end

        // stage valid
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[st] <= 1'b0;
            else if (en)
                vld_reg[st] <= vld_i;
        end

        // stage data
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[st]  <= rem_next;
                den_reg[st]  <= den_i;
                quo_reg[st]  <= quo_next;
                side_reg[st] <= side_i;
            end
        end
    end

    assign out_vld  = vld_reg[QW-1];
    assign quo      = quo_reg[QW-1];
    assign side_out = side_reg[QW-1];

endmodule

`default_nettype wire

FILE: design/pca_hsv_back.sv
// pca_hsv_back: hue/saturation update, hsv to rgb conversion and the
// output register; depends on pca_pkg
`default_nettype none

module pca_hsv_back #(
    parameter int QW = pca_pkg::DIV_QW
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            en,
    input  wire logic                            in_vld,
    input  wire logic [QW-1:0]                   hq,
    input  wire logic [QW-1:0]                   sq,
    input  wire pca_pkg::hsv_side_t              side,
    input  wire logic [pca_pkg::MODE_W-1:0]      mode,
    input  wire logic signed [pca_pkg::AMT_W-1:0] amount,
    output logic                                 out_vld,
    output pca_pkg::pix_out_t                    out_pix
);

    // stage registers
    logic                 d_vld_reg, e_vld_reg, f_vld_reg, g_vld_reg, h_vld_reg, o_vld_reg;
    logic [8:0]           d_h_reg;
    logic [7:0]           d_s_reg, e_s_reg;
    pca_pkg::hsv_side_t   d_side_reg, e_side_reg, f_side_reg, g_side_reg, h_side_reg;
    logic [2:0]           e_sec_reg, f_sec_reg, g_sec_reg, h_sec_reg;
    logic [5:0]           e_fr_reg;
    logic                 f_sz_reg, g_sz_reg, h_sz_reg;
    logic [2:0][13:0]     f_x_reg;
    logic [2:0][19:0]     g_m_reg;
    logic [2:0][7:0]      h_c_reg;
    pca_pkg::pix_out_t    o_pix_reg;

    logic [7:0]           sq_eff;
    logic signed [11:0]   s_sum;
    logic signed [11:0]   h_sum;
    logic [9:0]           h_clip;
    logic [8:0]           h_wrap;
    logic [8:0]           d_h_next;
    logic [7:0]           d_s_next;
    logic [19:0]          sec_prod;
    logic [2:0]           e_sec_next;
    logic [5:0]           e_fr_next;
    logic [2:0][13:0]     f_x_next;
    logic [2:0][19:0]     g_m_next;
    logic [2:0][40:0]     h_prod;
    logic [2:0][7:0]      h_c_next;
    pca_pkg::pix_out_t    o_pix_next;
    logic [7:0]           cv, cp, cq, ct;

    // new hue and saturation
    always_comb
    begin
        sq_eff = side.achrom ? 8'd0 : sq[7:0];
        s_sum  = $signed({4'b0, sq_eff}) + 12'(amount);
        h_sum  = (side.achrom ? -12'sd1 : $signed(12'(hq))) + 12'(amount);
        if (h_sum < 12'sd0)
            h_clip = '0;
        else if (h_sum > 12'sd720)
            h_clip = 10'd720;
        else
            h_clip = h_sum[9:0];
        if (h_clip >= 10'd720)
            h_wrap = '0;
        else if (h_clip >= 10'd360)
            h_wrap = 9'(h_clip - 10'd360);
        else
            h_wrap = h_clip[8:0];
        if (mode == pca_pkg::MODE_SAT)
        begin
            d_h_next = side.achrom ? 9'd0 : hq[8:0];
            d_s_next = pca_pkg::clamp_u8(14'(s_sum));
        end
        else
        begin
            d_h_next = h_wrap;
            d_s_next = sq_eff;
        end
    end

    // sector and fraction, h/60 by reciprocal
    always_comb
    begin
        sec_prod   = 20'(d_h_reg) * 20'd1093;
        e_sec_next = sec_prod[18:16];
        e_fr_next  = 6'(d_h_reg - 9'(e_sec_next * 6'd60));
    end

    // weights for p, q and t
    always_comb
    begin
        f_x_next[0] = 14'd15300 - 14'(e_s_reg * 6'd60);
        f_x_next[1] = 14'd15300 - 14'(14'(e_s_reg) * 14'(e_fr_reg));
        f_x_next[2] = 14'd15300 - 14'(14'(e_s_reg) * 14'(6'd60 - e_fr_reg));
    end

    // value times weight, rounded, pre-divided by four
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            g_m_next[i] = 20'((22'(f_side_reg.val) * 22'(f_x_reg[i]) + 22'd7650) >> 2);
    end

    // divide by 3825 through the reciprocal
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            h_prod[i]   = 41'(g_m_reg[i]) * 41'd1122868;
            h_c_next[i] = h_prod[i][39:32];
        end
    end

    // sector select and final mux
    always_comb
    begin
        cv = h_side_reg.val;
        cp = h_c_reg[0];
        cq = h_c_reg[1];
        ct = h_c_reg[2];
        o_pix_next = h_side_reg.res;
        if (mode == pca_pkg::MODE_SAT || mode == pca_pkg::MODE_HUE)
        begin
            if (h_sz_reg)
            begin
                o_pix_next.red_out   = cv;
                o_pix_next.green_out = cv;
                o_pix_next.blue_out  = cv;
            end
            else
            begin
                case (h_sec_reg)
                    3'd0:
                    begin
                        o_pix_next.red_out = cv; o_pix_next.green_out = ct;
                        o_pix_next.blue_out = cp;
                    end
                    3'd1:
                    begin
                        o_pix_next.red_out = cq; o_pix_next.green_out = cv;
                        o_pix_next.blue_out = cp;
                    end
                    3'd2:
                    begin
                        o_pix_next.red_out = cp; o_pix_next.green_out = cv;
                        o_pix_next.blue_out = ct;
                    end
                    3'd3:
                    begin
                        o_pix_next.red_out = cp; o_pix_next.green_out = cq;
                        o_pix_next.blue_out = cv;
                    end
                    3'd4:
                    begin
                        o_pix_next.red_out = ct; o_pix_next.green_out = cp;
                        o_pix_next.blue_out = cv;
                    end
                    default:
                    begin
                        o_pix_next.red_out = cv; o_pix_next.green_out = cp;
                        o_pix_next.blue_out = cq;
                    end
                endcase
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
            f_vld_reg <= 1'b0;
            g_vld_reg <= 1'b0;
            h_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            d_vld_reg <= in_vld;
            e_vld_reg <= d_vld_reg;
            f_vld_reg <= e_vld_reg;
            g_vld_reg <= f_vld_reg;
            h_vld_reg <= g_vld_reg;
            o_vld_reg <= h_vld_reg;
        end
    end

    // stage data
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_h_reg    <= d_h_next;
            d_s_reg    <= d_s_next;
            d_side_reg <= side;
            e_sec_reg  <= e_sec_next;
            e_fr_reg   <= e_fr_next;
            e_s_reg    <= d_s_reg;
            e_side_reg <= d_side_reg;
            f_x_reg    <= f_x_next;
            f_sec_reg  <= e_sec_reg;
            f_sz_reg   <= (e_s_reg == 8'd0);
            f_side_reg <= e_side_reg;
            g_m_reg    <= g_m_next;
            g_sec_reg  <= f_sec_reg;
            g_sz_reg   <= f_sz_reg;
            g_side_reg <= f_side_reg;
            h_c_reg    <= h_c_next;
            h_sec_reg  <= g_sec_reg;
            h_sz_reg   <= g_sz_reg;
            h_side_reg <= g_side_reg;
            o_pix_reg  <= o_pix_next;
        end
    end

    assign out_vld = o_vld_reg;
    assign out_pix = o_pix_reg;

endmodule

`default_nettype wire

FILE: dv/pixel_color_adjust_test.sv
// pixel_color_adjust_test: self-checking testbench for the pixel colour adjust block
// depends on pca_pkg and pixel_color_adjust; predicts every pixel and checks results in order
`default_nettype none

module pixel_color_adjust_test;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic pix_valid = 1'b0;
    logic pix_ready;
    pca_pkg::pix_in_t pix = '0;
    logic res_valid;
    logic res_ready = 1'b0;
    pca_pkg::pix_out_t res;
    logic cfg_we = 1'b0;
    logic cfg_index = 1'b0;
    logic [pca_pkg::AMT_W-1:0] cfg_data = '0;

    // predictor copy of the registers
    logic [pca_pkg::MODE_W-1:0] cur_mode = pca_pkg::MODE_BRIGHT;
    int cur_amount = 0;

    pca_pkg::pix_out_t expected_pixels[$];
    bit failed = 1'b0;
    bit sink_stalls = 1'b1;

    pixel_color_adjust dut (
        .clk(clk), .rst_n(rst_n),
        .pix_valid(pix_valid), .pix_ready(pix_ready), .pix(pix),
        .res_valid(res_valid), .res_ready(res_ready), .res(res),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int clamp_int(int x, int lo, int hi);
        if (x < lo)
            return lo;
        if (x > hi)
            return hi;
        return x;
    endfunction

    // one hsv-to-rgb channel with weight k, rounded half up
    function automatic int hsv_weight(int v, int s, int k);
        return (2 * v * (15300 - s * k) + 15300) / 30600;
    endfunction

    function automatic pca_pkg::pix_out_t adjusted_pixel(pca_pkg::pix_in_t p);
        int r, g, b, a, mx, mn, delta, num, h, s, v, y, sector, fr, cp, cq, ct;
        pca_pkg::pix_out_t o;
        r = p.red_in; g = p.green_in; b = p.blue_in; a = p.alpha_in;
        case (cur_mode)
            pca_pkg::MODE_BRIGHT:
            begin
                r = clamp_int(r + cur_amount, 0, 255);
                g = clamp_int(g + cur_amount, 0, 255);
                b = clamp_int(b + cur_amount, 0, 255);
            end
            pca_pkg::MODE_CONTRAST:
            begin
                r = clamp_int((r - 127) * (cur_amount + 128) / 128 + 127, 0, 255);
                g = clamp_int((g - 127) * (cur_amount + 128) / 128 + 127, 0, 255);
                b = clamp_int((b - 127) * (cur_amount + 128) / 128 + 127, 0, 255);
            end
            pca_pkg::MODE_SAT, pca_pkg::MODE_HUE:
            begin
                // forward hexcone conversion
                mx = r; if (g > mx) mx = g; if (b > mx) mx = b;
                mn = r; if (g < mn) mn = g; if (b < mn) mn = b;
                delta = mx - mn;
                v = mx;
                if (delta == 0)
                begin
                    h = -1;
                    s = 0;
                end
                else
                begin
                    s = ((delta * 65535 * 2 + mx) / (2 * mx)) >>> 8;
                    if (r == mx)
                    begin
                        num = 6000 * (g - b);
                        if (num < 0)
                            num += 36000 * delta;
                    end
                    else if (g == mx)
                        num = 12000 * delta + 6000 * (b - r);
                    else
                        num = 24000 * delta + 6000 * (r - g);
                    h = ((2 * num + delta) / (2 * delta)) / 100;
                end
                if (cur_mode == pca_pkg::MODE_SAT)
                begin
                    if (h < 0)
                        h = 0;
                    s = clamp_int(s + cur_amount, 0, 255);
                end
                else
                    h = clamp_int(h + cur_amount, 0, 720) % 360;
                // back to rgb
                if (s == 0)
                begin
                    r = v; g = v; b = v;
                end
                else
                begin
                    sector = h / 60;
                    fr = h % 60;
                    cp = hsv_weight(v, s, 60);
                    cq = hsv_weight(v, s, fr);
                    ct = hsv_weight(v, s, 60 - fr);
                    case (sector)
                        0: begin r = v;  g = ct; b = cp; end
                        1: begin r = cq; g = v;  b = cp; end
                        2: begin r = cp; g = v;  b = ct; end
                        3: begin r = cp; g = cq; b = v;  end
                        4: begin r = ct; g = cp; b = v;  end
                        default: begin r = v; g = cp; b = cq; end
                    endcase
                end
            end
            pca_pkg::MODE_GRAY:
            begin
                y = (13933 * r + 46871 * g + 4732 * b + 32768) >>> 16;
                r = y; g = y; b = y;
            end
            pca_pkg::MODE_NEG:
            begin
                r = 255 - r; g = 255 - g; b = 255 - b;
            end
            pca_pkg::MODE_OPACITY:
                a = clamp_int(a + cur_amount, 0, 255);
            default: ;
        endcase
        o.red_out = r[7:0];
        o.green_out = g[7:0];
        o.blue_out = b[7:0];
        o.alpha_out = a[7:0];
        return o;
    endfunction

    task automatic write_reg(logic idx, logic [pca_pkg::AMT_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == pca_pkg::REG_MODE)
            cur_mode = val[pca_pkg::MODE_W-1:0];
        else
            cur_amount = $signed(val);
    endtask

    // wait for the pipeline to drain, then set both registers
    task automatic set_config(logic [pca_pkg::MODE_W-1:0] m, int amt);
        logic [pca_pkg::AMT_W-1:0] raw;
        pix_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        raw = amt[pca_pkg::AMT_W-1:0];
        write_reg(pca_pkg::REG_MODE, {{(pca_pkg::AMT_W-pca_pkg::MODE_W){1'b0}}, m});
        write_reg(pca_pkg::REG_AMOUNT, raw);
    endtask

    // send one pixel beat, with a random gap in front; valid stays up
    // after the beat so that a following beat can go back to back
    task automatic send_pixel(pca_pkg::pix_in_t p, bit gaps = 1'b1);
        int gap;
        gap = gaps ? $urandom_range(0, 11) : 0;
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            pix_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix <= p;
        expected_pixels.push_back(adjusted_pixel(p));
        @(posedge clk);
        while (!pix_ready)
            @(posedge clk);
    endtask

    function automatic pca_pkg::pix_in_t random_pixel();
        pca_pkg::pix_in_t p;
        p = $urandom;
        // bias red to the extremes; at times copy red to green and green to blue
        if ($urandom_range(0, 7) == 0)
            p.red_in = $urandom_range(0, 1) ? 8'hff : 8'h00;
        if ($urandom_range(0, 7) == 0)
            p.green_in = p.red_in;
        if ($urandom_range(0, 7) == 0)
            p.blue_in = p.green_in;
        return p;
    endfunction

    // result sink: random stalls, in-order check
    always @(posedge clk)
    begin
        pca_pkg::pix_out_t exp_pix;
        if (res_valid && res_ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("result beat with nothing expected: %h", res);
                failed = 1'b1;
            end
            else
            begin
                exp_pix = expected_pixels.pop_front();
                if (res.red_out !== exp_pix.red_out)
                begin
                    $error("red_out expected %0d actual %0d", exp_pix.red_out, res.red_out);
                    failed = 1'b1;
                end
                if (res.green_out !== exp_pix.green_out)
                begin
                    $error("green_out expected %0d actual %0d", exp_pix.green_out,
                           res.green_out);
                    failed = 1'b1;
                end
                if (res.blue_out !== exp_pix.blue_out)
                begin
                    $error("blue_out expected %0d actual %0d", exp_pix.blue_out, res.blue_out);
                    failed = 1'b1;
                end
                if (res.alpha_out !== exp_pix.alpha_out)
                begin
                    $error("alpha_out expected %0d actual %0d", exp_pix.alpha_out,
                           res.alpha_out);
                    failed = 1'b1;
                end
            end
        end
    end

    // ready is redrawn after every beat or stall stretch
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = sink_stalls ? $urandom_range(0, 11) : 0;
            if ($urandom_range(0, 3) == 0)
                stall = 0;
            if (stall != 0)
            begin
                res_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ready <= 1'b1;
            @(posedge clk);
            while (!res_valid)
                @(posedge clk);
        end
    end

    // extremes of every channel under each operation
    task automatic test_directed();
        logic [pca_pkg::MODE_W-1:0] m;
        for (int i = 0; i < 8; i++)
        begin
            m = pca_pkg::MODE_W'(i);
            set_config(m, (i % 2 == 0) ? 60 : -60);
            send_pixel('{8'h00, 8'h00, 8'h00, 8'h00});
            send_pixel('{8'hff, 8'hff, 8'hff, 8'hff});
            send_pixel('{8'hff, 8'h00, 8'h80, 8'h7f});
        end
        // contrast inverted about mid grey, achromatic hue and saturation
        set_config(pca_pkg::MODE_CONTRAST, -300);
        send_pixel('{8'h10, 8'hf0, 8'h7f, 8'h01});
        set_config(pca_pkg::MODE_HUE, 200);
        send_pixel('{8'h40, 8'h40, 8'h40, 8'h20});
        set_config(pca_pkg::MODE_SAT, 100);
        send_pixel('{8'h80, 8'h80, 8'h80, 8'h20});
    endtask

    // random pixels across many register settings, extremes included
    task automatic test_random();
        int amt;
        for (int phase = 0; phase < 44; phase++)
        begin
            case (phase % 4)
                0: amt = -512;
                1: amt = 511;
                default: amt = $urandom_range(0, 1) ? $urandom_range(0, 1023) - 512
                                                    : $urandom_range(0, 720) - 360;
            endcase
            set_config(pca_pkg::MODE_W'($urandom_range(0, 7)), amt);
            sink_stalls = (phase % 5 != 4);
            for (int k = 0; k < 25; k++)
                send_pixel(random_pixel(), phase % 5 != 4);
        end
        sink_stalls = 1'b1;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random();
        pix_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (!failed)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
design/pca_pkg.sv
design/pca_div.sv
design/pca_hsv_back.sv
design/pixel_color_adjust.sv
dv/pixel_color_adjust_test.sv
